[src/gfbc_pkg.sv]
`timescale 1ns / 1ps

package gfbc_pkg;

    // Face set
    localparam int NUM_FACES  = 42;
    localparam int PENT_COUNT = 12;
    localparam int FACE_W     = 6;
    localparam int RANK_DEPTH = 3;

    // Point components are Q1.14; dot products are Q2.28 in 34 signed bits
    localparam int PT_W    = 16;
    localparam int IN_FRAC = 14;
    localparam int DOT_W   = 34;

    // Gap threshold register
    localparam int                GAP_W     = 30;
    localparam logic [GAP_W-1:0]  GAP_MASK  = 30'h3FFF_FFFF;
    localparam logic [GAP_W-1:0]  GAP_RESET = 30'd21474836;

    // Axis select for the centre table
    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;
    localparam logic [1:0] AXIS_Z = 2'd2;

    // Face issued to the dot-product unit
    typedef struct packed {
        logic              vld;
        logic              last;
        logic [FACE_W-1:0] face;
    } issue_t;

    // Candidate moving down the ranking chain
    typedef struct packed {
        logic                    vld;
        logic                    last;
        logic signed [DOT_W-1:0] dot;
        logic [FACE_W-1:0]       face;
    } cand_t;

    // Entry held in one ranking cell
    typedef struct packed {
        logic                    vld;
        logic signed [DOT_W-1:0] dot;
        logic [FACE_W-1:0]       face;
    } entry_t;

    // Centre magnitudes in Q1.31: 0, 1/sqrt(1+phi^2), phi/sqrt(1+phi^2), 1, 1/2, phi/2, 1/(2 phi)
    function automatic logic [31:0] mag31(input logic [2:0] k);
        logic [31:0] m;
        case (k)
            3'd1:    m = 32'd1128998967;
            3'd2:    m = 32'd1826758701;
            3'd3:    m = 32'd2147483648;
            3'd4:    m = 32'd1073741824;
            3'd5:    m = 32'd1737350766;
            3'd6:    m = 32'd663608942;
            default: m = 32'd0;
        endcase
        return m;
    endfunction

    // Signed magnitude codes {x, y, z} per face; vertices first, then edge midpoints
    function automatic logic [11:0] face_codes(input logic [FACE_W-1:0] face);
        logic [11:0] c;
        case (face)
            6'd0:    c = {-4'sd1,  4'sd2,  4'sd0};
            6'd1:    c = { 4'sd1,  4'sd2,  4'sd0};
            6'd2:    c = {-4'sd1, -4'sd2,  4'sd0};
            6'd3:    c = { 4'sd1, -4'sd2,  4'sd0};
            6'd4:    c = { 4'sd0, -4'sd1,  4'sd2};
            6'd5:    c = { 4'sd0,  4'sd1,  4'sd2};
            6'd6:    c = { 4'sd0, -4'sd1, -4'sd2};
            6'd7:    c = { 4'sd0,  4'sd1, -4'sd2};
            6'd8:    c = { 4'sd2,  4'sd0, -4'sd1};
            6'd9:    c = { 4'sd2,  4'sd0,  4'sd1};
            6'd10:   c = {-4'sd2,  4'sd0, -4'sd1};
            6'd11:   c = {-4'sd2,  4'sd0,  4'sd1};
            6'd12:   c = {-4'sd5,  4'sd4,  4'sd6};
            6'd13:   c = {-4'sd4,  4'sd6,  4'sd5};
            6'd14:   c = {-4'sd6,  4'sd5,  4'sd4};
            6'd15:   c = { 4'sd6,  4'sd5,  4'sd4};
            6'd16:   c = { 4'sd0,  4'sd3,  4'sd0};
            6'd17:   c = { 4'sd6,  4'sd5, -4'sd4};
            6'd18:   c = {-4'sd6,  4'sd5, -4'sd4};
            6'd19:   c = {-4'sd4,  4'sd6, -4'sd5};
            6'd20:   c = {-4'sd5,  4'sd4, -4'sd6};
            6'd21:   c = {-4'sd3,  4'sd0,  4'sd0};
            6'd22:   c = { 4'sd4,  4'sd6,  4'sd5};
            6'd23:   c = { 4'sd5,  4'sd4,  4'sd6};
            6'd24:   c = {-4'sd4, -4'sd6,  4'sd5};
            6'd25:   c = { 4'sd0,  4'sd0,  4'sd3};
            6'd26:   c = {-4'sd5, -4'sd4, -4'sd6};
            6'd27:   c = {-4'sd5, -4'sd4,  4'sd6};
            6'd28:   c = { 4'sd0,  4'sd0, -4'sd3};
            6'd29:   c = {-4'sd4, -4'sd6, -4'sd5};
            6'd30:   c = { 4'sd5,  4'sd4, -4'sd6};
            6'd31:   c = { 4'sd4,  4'sd6, -4'sd5};
            6'd32:   c = { 4'sd5, -4'sd4,  4'sd6};
            6'd33:   c = { 4'sd4, -4'sd6,  4'sd5};
            6'd34:   c = { 4'sd6, -4'sd5,  4'sd4};
            6'd35:   c = {-4'sd6, -4'sd5,  4'sd4};
            6'd36:   c = { 4'sd0, -4'sd3,  4'sd0};
            6'd37:   c = {-4'sd6, -4'sd5, -4'sd4};
            6'd38:   c = { 4'sd6, -4'sd5, -4'sd4};
            6'd39:   c = { 4'sd4, -4'sd6, -4'sd5};
            6'd40:   c = { 4'sd5, -4'sd4, -4'sd6};
            6'd41:   c = { 4'sd3,  4'sd0,  4'sd0};
            default: c = 12'd0;
        endcase
        return c;
    endfunction

    // One centre component in Q1.fb, magnitude rounded half up, sign applied after
    function automatic logic signed [32:0] face_comp(input logic [FACE_W-1:0] face,
                                                     input logic [1:0]        axis,
                                                     input int                fb);
        logic [11:0]        codes;
        logic signed [3:0]  code;
        logic [2:0]         k;
        logic [32:0]        mag;
        logic [32:0]        m;
        int                 sh;
        codes = face_codes(face);
        case (axis)
            AXIS_X:  code = codes[11:8];
            AXIS_Y:  code = codes[7:4];
            default: code = codes[3:0];
        endcase
        k   = code[3] ? 3'(-code) : code[2:0];
        mag = {1'b0, mag31(k)};
        sh  = 31 - fb;
        m   = (mag + (33'd1 << (sh - 1))) >> sh;
        return code[3] ? -$signed(m) : $signed(m);
    endfunction

endpackage

[src/gfbc_dot_unit.sv]
`timescale 1ns / 1ps

module gfbc_dot_unit #(
    parameter int FRACTION_BITS = 14
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  gfbc_pkg::issue_t                   issue,
    input  logic signed [gfbc_pkg::PT_W-1:0]   pt_x,
    input  logic signed [gfbc_pkg::PT_W-1:0]   pt_y,
    input  logic signed [gfbc_pkg::PT_W-1:0]   pt_z,
    output gfbc_pkg::cand_t                    cand
);
    import gfbc_pkg::*;

    localparam int COMP_W = FRACTION_BITS + 2;
    localparam int PROD_W = PT_W + COMP_W;
    localparam int RAW_W  = PROD_W + 2;

    logic signed [32:0]        comp_x_full, comp_y_full, comp_z_full;
    logic signed [COMP_W-1:0]  comp_x, comp_y, comp_z;
    logic signed [PROD_W-1:0]  prod_x_reg, prod_y_reg, prod_z_reg;
    issue_t                    stage_a_reg;
    logic signed [RAW_W-1:0]   raw_sum;
    logic signed [DOT_W-1:0]   dot_q28;
    cand_t                     cand_reg;

    // Centre table lookup for the face being issued
    assign comp_x_full = face_comp(issue.face, AXIS_X, FRACTION_BITS);
    assign comp_y_full = face_comp(issue.face, AXIS_Y, FRACTION_BITS);
    assign comp_z_full = face_comp(issue.face, AXIS_Z, FRACTION_BITS);
    assign comp_x = comp_x_full[COMP_W-1:0];
    assign comp_y = comp_y_full[COMP_W-1:0];
    assign comp_z = comp_z_full[COMP_W-1:0];

    // Stage A: three products
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stage_a_reg <= '0;
        end else begin
            stage_a_reg <= issue;
        end
        prod_x_reg <= pt_x * comp_x;
        prod_y_reg <= pt_y * comp_y;
        prod_z_reg <= pt_z * comp_z;
    end

    // Stage B: sum and scale to Q2.28
    assign raw_sum = RAW_W'(prod_x_reg) + RAW_W'(prod_y_reg) + RAW_W'(prod_z_reg);

    generate
        if (FRACTION_BITS > IN_FRAC) begin : g_round
            localparam int SH = FRACTION_BITS - IN_FRAC;
            localparam logic signed [RAW_W-1:0] HALF = RAW_W'(1) <<< (SH - 1);
            logic signed [RAW_W-1:0] rounded;
            assign rounded = (raw_sum + HALF) >>> SH;
            assign dot_q28 = rounded[DOT_W-1:0];
        end else if (FRACTION_BITS < IN_FRAC) begin : g_widen
            localparam int SH = IN_FRAC - FRACTION_BITS;
            assign dot_q28 = DOT_W'(raw_sum) <<< SH;
        end else begin : g_exact
            assign dot_q28 = DOT_W'(raw_sum);
        end
    endgenerate

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cand_reg.vld  <= 1'b0;
            cand_reg.last <= 1'b0;
        end else begin
            cand_reg.vld  <= stage_a_reg.vld;
            cand_reg.last <= stage_a_reg.vld & stage_a_reg.last;
        end
        cand_reg.dot  <= dot_q28;
        cand_reg.face <= stage_a_reg.face;
    end

    assign cand = cand_reg;

endmodule

[src/gfbc_rank_cell.sv]
`timescale 1ns / 1ps

module gfbc_rank_cell (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              clear,
    input  gfbc_pkg::cand_t   cand_in,
    output gfbc_pkg::cand_t   cand_out,
    output gfbc_pkg::entry_t  held
);
    import gfbc_pkg::*;

    entry_t held_reg;
    cand_t  pass_reg;
    logic   wins;

    // Larger dot wins; equal dots go to the lower face number
    assign wins = cand_in.vld &&
                  (!held_reg.vld || (cand_in.dot > held_reg.dot) ||
                   ((cand_in.dot == held_reg.dot) && (cand_in.face < held_reg.face)));

    // Keep the better of held and incoming, hand the other to the next cell
    always_ff @(posedge aclk) begin
        if (!aresetn || clear) begin
            held_reg.vld  <= 1'b0;
            pass_reg.vld  <= 1'b0;
            pass_reg.last <= 1'b0;
        end else begin
            pass_reg.last <= cand_in.vld & cand_in.last;
            if (wins) begin
                held_reg.vld <= 1'b1;
                pass_reg.vld <= held_reg.vld;
            end else begin
                pass_reg.vld <= cand_in.vld;
            end
        end
        if (wins) begin
            held_reg.dot  <= cand_in.dot;
            held_reg.face <= cand_in.face;
            pass_reg.dot  <= held_reg.dot;
            pass_reg.face <= held_reg.face;
        end else begin
            pass_reg.dot  <= cand_in.dot;
            pass_reg.face <= cand_in.face;
        end
    end

    assign cand_out = pass_reg;
    assign held     = held_reg;

endmodule

[src/geodesic_face_boundary_classifier_unit.sv]
`timescale 1ns / 1ps

// Geodesic face boundary classifier.
// Input channel s_*: one point on the unit sphere, three signed Q1.14 components.
// Result channel m_*: nearest and second face (0..41, faces below 12 are pentagons),
// the Q2.28 gap between the two best dot products (saturated to 30 bits) and a
// boundary flag. cfg_we/cfg_wdata write the Q2.28 gap threshold at any edge; write it
// only while no item is in flight.
// One item is worked on at a time. The 42 faces go one per cycle through a shared
// dot-product unit (two register stages) into a chain of three ranking cells; a new
// item is taken only after the previous result has been loaded into the output register.
// s_ready is high whenever no item is in work, even while a result waits on m_ready;
// a finished result that finds the output register still full waits in the block
// and holds off the next item until the output is taken.
// Reset (aresetn low, synchronous) empties the pipeline and the output register and
// loads the threshold with its default of about 0.08.
module geodesic_face_boundary_classifier_unit #(
    parameter int FRACTION_BITS = 14
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic signed [gfbc_pkg::PT_W-1:0]      s_point_x,
    input  logic signed [gfbc_pkg::PT_W-1:0]      s_point_y,
    input  logic signed [gfbc_pkg::PT_W-1:0]      s_point_z,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic [gfbc_pkg::FACE_W-1:0]           m_nearest_face,
    output logic [gfbc_pkg::FACE_W-1:0]           m_second_face,
    output logic                                  m_nearest_is_pentagon,
    output logic [gfbc_pkg::GAP_W-1:0]            m_top_gap,
    output logic                                  m_near_boundary,
    input  logic                                  cfg_we,
    input  logic [gfbc_pkg::GAP_W-1:0]            cfg_wdata
);
    import gfbc_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN,
        ST_FINISH
    } state_t;

    state_t                  state_reg;
    logic [FACE_W-1:0]       face_cnt_reg;
    logic signed [PT_W-1:0]  pt_x_reg, pt_y_reg, pt_z_reg;
    logic [GAP_W-1:0]        gap_thr_reg;
    logic [DOT_W-1:0]        gap1_reg, gap2_reg;
    logic [FACE_W-1:0]       id0_reg, id1_reg, id2_reg;
    logic                    m_valid_reg;
    logic [FACE_W-1:0]       nearest_reg, second_reg;
    logic                    is_pent_reg, near_bnd_reg;
    logic [GAP_W-1:0]        top_gap_reg;

    logic                    accept;
    logic                    out_free;
    issue_t                  issue;
    cand_t                   chain [0:RANK_DEPTH];
    entry_t                  held  [0:RANK_DEPTH-1];

    logic                    p0, p1, p2;
    logic [DOT_W:0]          gap1_x2, gap2_x2;
    logic [DOT_W:0]          thr_x3;
    logic                    near_bnd;
    logic [GAP_W-1:0]        top_gap;

    assign s_ready  = (state_reg == ST_IDLE);
    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    // Face sequencer feeding the dot-product unit
    assign issue.vld  = (state_reg == ST_RUN);
    assign issue.last = (face_cnt_reg == FACE_W'(NUM_FACES - 1));
    assign issue.face = face_cnt_reg;

    gfbc_dot_unit #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_dot (
        .aclk    (aclk),
        .aresetn (aresetn),
        .issue   (issue),
        .pt_x    (pt_x_reg),
        .pt_y    (pt_y_reg),
        .pt_z    (pt_z_reg),
        .cand    (chain[0])
    );

    // Ranking chain: cell k ends up holding the k-th best face
    generate
        for (genvar k = 0; k < RANK_DEPTH; k++) begin : g_cell
            gfbc_rank_cell u_cell (
                .aclk     (aclk),
                .aresetn  (aresetn),
                .clear    (accept),
                .cand_in  (chain[k]),
                .cand_out (chain[k+1]),
                .held     (held[k])
            );
        end
    endgenerate

    // Boundary tests on the registered gaps
    assign p0      = (id0_reg < FACE_W'(PENT_COUNT));
    assign p1      = (id1_reg < FACE_W'(PENT_COUNT));
    assign p2      = (id2_reg < FACE_W'(PENT_COUNT));
    assign gap1_x2 = {gap1_reg, 1'b0};
    assign gap2_x2 = {gap2_reg, 1'b0};
    assign thr_x3  = (DOT_W + 1)'(gap_thr_reg) + (DOT_W + 1)'({gap_thr_reg, 1'b0});
    assign near_bnd = p0 || (gap1_reg < DOT_W'(gap_thr_reg))
                    || (p1 && (gap1_x2 < thr_x3))
                    || (p2 && (gap2_x2 < thr_x3));
    assign top_gap = (gap1_reg > DOT_W'(GAP_MASK)) ? GAP_MASK : gap1_reg[GAP_W-1:0];

    // Control, threshold register and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            face_cnt_reg <= '0;
            gap_thr_reg  <= GAP_RESET;
            m_valid_reg  <= 1'b0;
        end else begin
            if (cfg_we) begin
                gap_thr_reg <= cfg_wdata;
            end
            // a finishing item refills the output register in the same cycle
            if (m_valid_reg && m_ready && (state_reg != ST_FINISH)) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        face_cnt_reg <= '0;
                        state_reg    <= ST_RUN;
                    end
                end
                ST_RUN: begin
                    face_cnt_reg <= face_cnt_reg + 1'b1;
                    if (issue.last) begin
                        state_reg <= ST_DRAIN;
                    end
                end
                ST_DRAIN: begin
                    if (chain[RANK_DEPTH].last) begin
                        state_reg <= ST_FINISH;
                    end
                end
                ST_FINISH: begin
                    if (out_free) begin
                        m_valid_reg <= 1'b1;
                        state_reg   <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
        if (accept) begin
            pt_x_reg <= s_point_x;
            pt_y_reg <= s_point_y;
            pt_z_reg <= s_point_z;
        end
        if (state_reg == ST_DRAIN && chain[RANK_DEPTH].last) begin
            gap1_reg <= DOT_W'(held[0].dot - held[1].dot);
            gap2_reg <= DOT_W'(held[0].dot - held[2].dot);
            id0_reg  <= held[0].face;
            id1_reg  <= held[1].face;
            id2_reg  <= held[2].face;
        end
        if (state_reg == ST_FINISH && out_free) begin
            nearest_reg  <= id0_reg;
            second_reg   <= id1_reg;
            is_pent_reg  <= p0;
            top_gap_reg  <= top_gap;
            near_bnd_reg <= near_bnd;
        end
    end

    assign m_valid               = m_valid_reg;
    assign m_nearest_face        = nearest_reg;
    assign m_second_face         = second_reg;
    assign m_nearest_is_pentagon = is_pent_reg;
    assign m_top_gap             = top_gap_reg;
    assign m_near_boundary       = near_bnd_reg;

endmodule

[dv/tb_geodesic_face_boundary_classifier_unit.sv]
`timescale 1ns / 1ps

module tb_geodesic_face_boundary_classifier_unit;
    import gfbc_pkg::*;

    // One classification, with the point kept for messages
    typedef struct {
        shortint             px;
        shortint             py;
        shortint             pz;
        logic [FACE_W-1:0]   nearest_face;
        logic [FACE_W-1:0]   second_face;
        logic                nearest_is_pentagon;
        logic [GAP_W-1:0]    top_gap;
        logic                near_boundary;
    } face_result_t;

    // Expected classifications in order, plus the face-centre table
    class face_scoreboard;
        byte          code_tab [NUM_FACES][3];
        face_result_t expected_faces [$];
        int           mismatch_count;

        function new();
            mismatch_count = 0;
            // signed magnitude code per axis; vertices 0..11, edge midpoints 12..41
            code_tab = '{
                '{-1, 2, 0}, '{ 1, 2, 0}, '{-1,-2, 0}, '{ 1,-2, 0},
                '{ 0,-1, 2}, '{ 0, 1, 2}, '{ 0,-1,-2}, '{ 0, 1,-2},
                '{ 2, 0,-1}, '{ 2, 0, 1}, '{-2, 0,-1}, '{-2, 0, 1},
                '{-5, 4, 6}, '{-4, 6, 5}, '{-6, 5, 4}, '{ 6, 5, 4},
                '{ 0, 3, 0}, '{ 6, 5,-4}, '{-6, 5,-4}, '{-4, 6,-5},
                '{-5, 4,-6}, '{-3, 0, 0}, '{ 4, 6, 5}, '{ 5, 4, 6},
                '{-4,-6, 5}, '{ 0, 0, 3}, '{-5,-4,-6}, '{-5,-4, 6},
                '{ 0, 0,-3}, '{-4,-6,-5}, '{ 5, 4,-6}, '{ 4, 6,-5},
                '{ 5,-4, 6}, '{ 4,-6, 5}, '{ 6,-5, 4}, '{-6,-5, 4},
                '{ 0,-3, 0}, '{-6,-5,-4}, '{ 6,-5,-4}, '{ 4,-6,-5},
                '{ 5,-4,-6}, '{ 3, 0, 0}
            };
        endfunction

        // Centre component in Q1.14: 1/sqrt(1+phi^2), phi/sqrt(1+phi^2), 1, 1/2,
        // phi/2, 1/(2 phi), magnitudes rounded half up
        function int centre_q14(int face, int axis);
            int c;
            int m;
            c = code_tab[face][axis];
            case (c < 0 ? -c : c)
                1:       m = 8614;
                2:       m = 13937;
                3:       m = 16384;
                4:       m = 8192;
                5:       m = 13255;
                6:       m = 5063;
                default: m = 0;
            endcase
            return (c < 0) ? -m : m;
        endfunction

        // Rank the three largest dot products; Q1.14 x Q1.14 is already Q2.28
        function face_result_t classify_point(shortint x, shortint y, shortint z,
                                              logic [GAP_W-1:0] thr);
            face_result_t r;
            longint       dot;
            longint       best [3];
            longint       g1;
            longint       g2;
            longint       t;
            int           rank [3];
            bit           p0;
            bit           p1;
            bit           p2;
            rank = '{-1, -1, -1};
            best = '{0, 0, 0};
            for (int f = 0; f < NUM_FACES; f++) begin
                dot = longint'(x) * centre_q14(f, 0) + longint'(y) * centre_q14(f, 1)
                    + longint'(z) * centre_q14(f, 2);
                // strict compare keeps the lower face first on ties
                if (rank[0] < 0 || dot > best[0]) begin
                    best[2] = best[1]; rank[2] = rank[1];
                    best[1] = best[0]; rank[1] = rank[0];
                    best[0] = dot;     rank[0] = f;
                end else if (rank[1] < 0 || dot > best[1]) begin
                    best[2] = best[1]; rank[2] = rank[1];
                    best[1] = dot;     rank[1] = f;
                end else if (rank[2] < 0 || dot > best[2]) begin
                    best[2] = dot;     rank[2] = f;
                end
            end
            t  = longint'(thr);
            g1 = best[0] - best[1];
            g2 = best[0] - best[2];
            p0 = rank[0] < PENT_COUNT;
            p1 = rank[1] < PENT_COUNT;
            p2 = rank[2] < PENT_COUNT;
            r.px = x;
            r.py = y;
            r.pz = z;
            r.nearest_face        = FACE_W'(rank[0]);
            r.second_face         = FACE_W'(rank[1]);
            r.nearest_is_pentagon = p0;
            // saturate the reported gap, thresholds use the full difference
            r.top_gap       = (g1 > longint'(GAP_MASK)) ? GAP_MASK : GAP_W'(g1);
            r.near_boundary = p0 || (g1 < t) || (p1 && 2 * g1 < 3 * t)
                           || (p2 && 2 * g2 < 3 * t);
            return r;
        endfunction

        function void note_point(shortint x, shortint y, shortint z,
                                 logic [GAP_W-1:0] thr);
            expected_faces.push_back(classify_point(x, y, z, thr));
        endfunction

        function int pending();
            return expected_faces.size();
        endfunction

        function void check_result(face_result_t got);
            face_result_t want;
            if (expected_faces.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("%0t: result with nothing expected: near=%0d second=%0d",
                             $realtime, got.nearest_face, got.second_face);
                return;
            end
            want = expected_faces.pop_front();
            if (got.nearest_face !== want.nearest_face
                || got.second_face !== want.second_face
                || got.nearest_is_pentagon !== want.nearest_is_pentagon
                || got.top_gap !== want.top_gap
                || got.near_boundary !== want.near_boundary) begin
                mismatch_count++;
                if (mismatch_count <= 10) begin
                    $write("%0t: point (%0d,%0d,%0d) expected near=%0d second=%0d ",
                           $realtime, want.px, want.py, want.pz,
                           want.nearest_face, want.second_face);
                    $write("pent=%0b gap=%0d nb=%0b, ",
                           want.nearest_is_pentagon, want.top_gap, want.near_boundary);
                    $display("got near=%0d second=%0d pent=%0b gap=%0d nb=%0b",
                             got.nearest_face, got.second_face,
                             got.nearest_is_pentagon, got.top_gap, got.near_boundary);
                end
            end
        endfunction
    endclass

    logic                    aclk = 1'b0;
    logic                    aresetn = 1'b0;
    logic                    s_valid = 1'b0;
    logic                    s_ready;
    logic signed [PT_W-1:0]  s_point_x = '0;
    logic signed [PT_W-1:0]  s_point_y = '0;
    logic signed [PT_W-1:0]  s_point_z = '0;
    logic                    m_valid;
    logic                    m_ready = 1'b0;
    logic [FACE_W-1:0]       m_nearest_face;
    logic [FACE_W-1:0]       m_second_face;
    logic                    m_nearest_is_pentagon;
    logic [GAP_W-1:0]        m_top_gap;
    logic                    m_near_boundary;
    logic                    cfg_we = 1'b0;
    logic [GAP_W-1:0]        cfg_wdata = '0;

    face_scoreboard   board = new();
    logic [GAP_W-1:0] gap_thr = GAP_RESET;
    logic             steady = 1'b0;

    geodesic_face_boundary_classifier_unit dut (
        .aclk                  (aclk),
        .aresetn               (aresetn),
        .s_valid               (s_valid),
        .s_ready               (s_ready),
        .s_point_x             (s_point_x),
        .s_point_y             (s_point_y),
        .s_point_z             (s_point_z),
        .m_valid               (m_valid),
        .m_ready               (m_ready),
        .m_nearest_face        (m_nearest_face),
        .m_second_face         (m_second_face),
        .m_nearest_is_pentagon (m_nearest_is_pentagon),
        .m_top_gap             (m_top_gap),
        .m_near_boundary       (m_near_boundary),
        .cfg_we                (cfg_we),
        .cfg_wdata             (cfg_wdata)
    );

    always #1 aclk = ~aclk;

    // Result side back-pressure: random stalls in about 12 percent of cycles, none while steady
    always @(posedge aclk) begin
        if (steady) begin
            m_ready <= 1'b1;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= 12);
        end
    end

    // Check every accepted result
    always @(posedge aclk) begin
        face_result_t got;
        if (aresetn && m_valid && m_ready) begin
            got.px = 0;
            got.py = 0;
            got.pz = 0;
            got.nearest_face        = m_nearest_face;
            got.second_face         = m_second_face;
            got.nearest_is_pentagon = m_nearest_is_pentagon;
            got.top_gap             = m_top_gap;
            got.near_boundary       = m_near_boundary;
            board.check_result(got);
        end
    end

    // Present one point and hold it until accepted
    task automatic send_point(input shortint x, input shortint y, input shortint z);
        s_valid   <= 1'b1;
        s_point_x <= x;
        s_point_y <= y;
        s_point_z <= z;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        board.note_point(x, y, z, gap_thr);
    endtask

    // Random gap on the input side, long enough to land anywhere in the face sweep
    task automatic maybe_idle();
        if (!steady && $urandom_range(0, 99) < 12) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 60)) @(posedge aclk);
        end
    endtask

    // Threshold write once the block has drained
    task automatic set_threshold(input logic [GAP_W-1:0] value);
        s_valid <= 1'b0;
        while (board.pending() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_we  <= 1'b0;
        gap_thr = value;
        @(posedge aclk);
    endtask

    // Mostly points on the sphere, many of them between two centres; some raw patterns
    task automatic random_point(output shortint x, output shortint y, output shortint z);
        int  kind;
        int  a;
        int  b;
        real w;
        real vx;
        real vy;
        real vz;
        real n;
        real sc;
        kind = $urandom_range(0, 99);
        if (kind < 20) begin
            x = shortint'($urandom());
            y = shortint'($urandom());
            z = shortint'($urandom());
        end else begin
            if (kind < 55) begin
                a  = $urandom_range(0, NUM_FACES - 1);
                b  = $urandom_range(0, 1) ? $urandom_range(0, PENT_COUNT - 1)
                                          : $urandom_range(0, NUM_FACES - 1);
                w  = real'($urandom_range(0, 1000)) / 1000.0;
                vx = (1.0 - w) * board.centre_q14(a, 0) + w * board.centre_q14(b, 0)
                   + real'($urandom_range(0, 400)) - 200.0;
                vy = (1.0 - w) * board.centre_q14(a, 1) + w * board.centre_q14(b, 1)
                   + real'($urandom_range(0, 400)) - 200.0;
                vz = (1.0 - w) * board.centre_q14(a, 2) + w * board.centre_q14(b, 2)
                   + real'($urandom_range(0, 400)) - 200.0;
            end else begin
                vx = real'($urandom_range(0, 20000)) - 10000.0;
                vy = real'($urandom_range(0, 20000)) - 10000.0;
                vz = real'($urandom_range(0, 20000)) - 10000.0;
            end
            n = $sqrt(vx * vx + vy * vy + vz * vz);
            if (n < 1.0) begin
                vx = 1.0;
                vy = 0.0;
                vz = 0.0;
                n  = 1.0;
            end
            // a few points off the unit sphere
            sc = ($urandom_range(0, 9) == 0) ? real'($urandom_range(1, 32767)) : 16384.0;
            x = shortint'(int'(vx / n * sc));
            y = shortint'(int'(vy / n * sc));
            z = shortint'(int'(vz / n * sc));
        end
    endtask

    initial begin
        logic [GAP_W-1:0] thr_list [6];
        shortint          x;
        shortint          y;
        shortint          z;
        thr_list = '{30'd0, GAP_MASK, 30'd536870912, GAP_W'($urandom()), 30'd4000000,
                     GAP_RESET};
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed points at the reset threshold
        send_point(0, 0, 0);                   maybe_idle();
        send_point(16384, 0, 0);               maybe_idle();
        send_point(-16384, 0, 0);              maybe_idle();
        send_point(0, 16384, 0);               maybe_idle();
        send_point(0, -16384, 0);              maybe_idle();
        send_point(0, 0, 16384);               maybe_idle();
        send_point(0, 0, -16384);              maybe_idle();
        send_point(32767, 32767, 32767);       maybe_idle();
        send_point(-32768, -32768, -32768);    maybe_idle();
        send_point(-32768, 32767, 0);          maybe_idle();
        send_point(32767, -32768, -32768);     maybe_idle();
        send_point(1, 0, 0);                   maybe_idle();
        send_point(0, 0, -1);                  maybe_idle();
        send_point(-1, -1, -1);                maybe_idle();
        // exactly on two pentagon centres, then on hexagon centres
        send_point(8614, 13937, 0);            maybe_idle();
        send_point(-13937, 0, -8614);          maybe_idle();
        send_point(8192, 5063, 13255);         maybe_idle();
        send_point(-5063, -13255, -8192);      maybe_idle();
        // on the seam between a pentagon and its neighbouring hexagon
        send_point(4477, 15760, 0);            maybe_idle();

        // Random phases over several thresholds; one phase runs without gaps
        for (int p = 0; p < 6; p++) begin
            set_threshold(thr_list[p]);
            steady <= (p == 2);
            for (int i = 0; i < 100; i++) begin
                random_point(x, y, z);
                send_point(x, y, z);
                maybe_idle();
            end
        end

        s_valid <= 1'b0;
        steady  <= 1'b0;
        while (board.pending() != 0) @(posedge aclk);
        repeat (60) @(posedge aclk);
        if (board.mismatch_count == 0 && board.pending() == 0) begin
            $display("[geodesic_face_boundary_classifier_unit] OK");
        end else begin
            $display("[geodesic_face_boundary_classifier_unit] ERROR");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #1000000;
        $display("[geodesic_face_boundary_classifier_unit] ERROR");
        $finish;
    end

endmodule
